// File: hw/rtl/sche_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and a helper function for the SIO command host engine.
package sche_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int FRAME_BYTES  = 4;
    localparam int JOB_BYTES    = FRAME_BYTES + 1;
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX      = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;

    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DTR    = 2'd1;
    localparam logic [1:0] KIND_RD     = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [7:0] CH_NAK  = 8'h4E;
    localparam logic [7:0] CH_CMPL = 8'h43;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  device_id;
        logic [7:0]  command_code;
        logic [7:0]  aux_one;
        logic [7:0]  aux_two;
        logic [1:0]  transfer_mode;
        logic [15:0] transfer_length;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       dtr_level;
        logic       last;
    } t_out_word;

    // One queued job: a full command frame, a pair of transmit bytes, or one result.
    typedef struct packed {
        logic                       frame;
        logic                       pair;
        logic [1:0]                 kind;
        logic [JOB_BYTES-1:0][7:0]  bytes;
    } t_job;

    function automatic logic [7:0] sum_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, acc} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

endpackage

// File: hw/rtl/sche_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, tracks the exchange phase and issues jobs.
module sche_front import sche_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_word,
    output logic     o_push,
    output t_job     o_job
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_FIRST, PH_CMPL, PH_RDATA, PH_RSUM, PH_WDATA, PH_WACK, PH_FINAL
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [1:0]              r_mode, n_mode;
    logic [LENGTH_WIDTH-1:0] r_left, n_left;
    logic [7:0]              r_sum, n_sum;
    logic [LENGTH_WIDTH-1:0] left_dec;
    logic [7:0]              frame_ck;
    logic [7:0]              sum_next;

    assign left_dec = r_left - LENGTH_WIDTH'(1);
    assign sum_next = sum_add(r_sum, i_word.data_byte);
    assign frame_ck = sum_add(sum_add(sum_add(i_word.device_id, i_word.command_code),
                                      i_word.aux_one), i_word.aux_two);

    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        n_left  = r_left;
        n_sum   = r_sum;
        o_push  = 1'b0;
        o_job   = '0;
        if (i_accept) begin
            unique case (i_word.operation)
                OP_START: begin
                    n_mode          = i_word.transfer_mode;
                    n_left          = i_word.transfer_length[LENGTH_WIDTH-1:0];
                    n_sum           = 8'd0;
                    n_phase         = PH_FIRST;
                    o_push          = 1'b1;
                    o_job.frame     = 1'b1;
                    o_job.bytes[0]  = i_word.device_id;
                    o_job.bytes[1]  = i_word.command_code;
                    o_job.bytes[2]  = i_word.aux_one;
                    o_job.bytes[3]  = i_word.aux_two;
                    o_job.bytes[4]  = frame_ck;
                end
                OP_RX: begin
                    unique case (r_phase)
                        PH_FIRST: begin
                            if (r_mode == MODE_READ || r_mode == MODE_WRITE) begin
                                priority if (i_word.data_byte == CH_NAK) begin
                                    o_push         = 1'b1;
                                    o_job.kind     = KIND_STATUS;
                                    o_job.bytes[0] = i_word.data_byte;
                                    n_phase        = PH_IDLE;
                                end else if (r_mode == MODE_READ) begin
                                    n_phase = PH_CMPL;
                                end else if (r_left == '0) begin
                                    o_push         = 1'b1;
                                    o_job.kind     = KIND_TX;
                                    o_job.bytes[0] = r_sum;
                                    n_phase        = PH_WACK;
                                end else begin
                                    n_phase = PH_WDATA;
                                end
                            end else begin
                                n_phase = PH_FINAL;
                            end
                        end
                        PH_CMPL: begin
                            if (i_word.data_byte == CH_CMPL) begin
                                n_phase = (r_left == '0) ? PH_RSUM : PH_RDATA;
                            end else begin
                                o_push         = 1'b1;
                                o_job.kind     = KIND_STATUS;
                                o_job.bytes[0] = i_word.data_byte;
                                n_phase        = PH_IDLE;
                            end
                        end
                        PH_RDATA: begin
                            o_push         = 1'b1;
                            o_job.kind     = KIND_RD;
                            o_job.bytes[0] = i_word.data_byte;
                            n_left         = left_dec;
                            if (left_dec == '0) begin
                                n_phase = PH_RSUM;
                            end
                        end
                        PH_RSUM: begin
                            o_push         = 1'b1;
                            o_job.kind     = KIND_STATUS;
                            o_job.bytes[0] = CH_CMPL;
                            n_phase        = PH_IDLE;
                        end
                        PH_WACK: begin
                            if (i_word.data_byte == CH_NAK) begin
                                o_push         = 1'b1;
                                o_job.kind     = KIND_STATUS;
                                o_job.bytes[0] = i_word.data_byte;
                                n_phase        = PH_IDLE;
                            end else begin
                                n_phase = PH_FINAL;
                            end
                        end
                        PH_FINAL: begin
                            o_push         = 1'b1;
                            o_job.kind     = KIND_STATUS;
                            o_job.bytes[0] = i_word.data_byte;
                            n_phase        = PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                OP_PAYLOAD: begin
                    if (r_phase == PH_WDATA) begin
                        o_push         = 1'b1;
                        o_job.kind     = KIND_TX;
                        o_job.bytes[0] = i_word.data_byte;
                        n_sum          = sum_next;
                        n_left         = left_dec;
                        if (left_dec == '0) begin
                            o_job.pair     = 1'b1;
                            o_job.bytes[1] = sum_next;
                            n_phase        = PH_WACK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mode  <= 2'd0;
            r_left  <= '0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_sum   <= n_sum;
        end
    end

endmodule

// File: hw/rtl/sche_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the result sequencer.
module sche_queue import sche_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    t_job         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full       = (r_count == (QAW+1)'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

// File: hw/rtl/sche_back.sv
`timescale 1ns / 1ps
// Back end: expands queued jobs into result words behind an output register.
module sche_back import sche_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_word o_word
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    t_out_word  r_word;
    t_out_word  cur;
    logic       load;
    logic [2:0] sel;

    assign sel = r_idx - 3'd1;

    always_comb begin
        cur = '0;
        if (i_head.frame) begin
            unique case (r_idx)
                3'd0: begin
                    cur.kind      = KIND_DTR;
                    cur.dtr_level = 1'b1;
                end
                3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
                    cur.kind       = KIND_TX;
                    cur.byte_value = i_head.bytes[sel];
                end
                3'd6: begin
                    cur.kind = KIND_DTR;
                    cur.last = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_head.pair) begin
            cur.kind       = KIND_TX;
            cur.byte_value = r_idx[0] ? i_head.bytes[1] : i_head.bytes[0];
            cur.last       = r_idx[0];
        end else begin
            cur.kind       = i_head.kind;
            cur.byte_value = i_head.bytes[0];
            cur.last       = 1'b1;
        end
    end

    assign load  = i_head_valid && (!r_valid || !i_stall);
    assign o_pop = load && cur.last;
    assign n_idx = o_pop ? 3'd0 : (r_idx + 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= cur;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: hw/rtl/sio_command_host_engine.sv
`timescale 1ns / 1ps
// Top level of the SIO command host engine: front end, job queue and back end.
// With the queue empty, an accepted word passes the job queue and then the output register.
// Throughput: one input word per cycle while the four-entry job queue has room.
// Results leave the output register one per cycle when not stalled; a start yields seven.
// Reset is synchronous and active low; it empties the queue and returns the phase to idle.
module sio_command_host_engine import sche_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic push, pop, full, head_valid;
    t_job job, head;

    assign o_in_stall = full;

    sche_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && !full),
        .i_word   (i_in_word),
        .o_push   (push),
        .o_job    (job)
    );

    sche_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    sche_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_word       (o_out_word)
    );

endmodule

// File: dv/sio_command_host_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SIO command host engine, with directed and random exchanges.
module sio_command_host_engine_tb;
    import sche_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] CH_ACK     = 8'h41;
    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_AFTER   = 270;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum logic [3:0] {
        S_IDLE, S_ACK_WAIT, S_COMPLETE_WAIT, S_READ_DATA,
        S_READ_SUM, S_WRITE_DATA, S_WRITE_ACK, S_STATUS
    } t_host_state;

    typedef struct packed {
        t_in_word  word;
        logic      typed;
        logic      typed_has;
        t_out_word typed_res;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_host_state             st = S_IDLE;
    logic [1:0]              cur_mode = MODE_NONE;
    logic [LENGTH_WIDTH-1:0] left = '0;
    logic [7:0]              wsum = '0;
    t_out_word               step_results[$];
    t_out_word               pending_results[$];
    t_row                    dir_rows[$];

    int  errors = 0;
    int  cycles = 0;
    int  words_sent = 0;
    int  rand_items = 0;
    int  results_seen = 0;
    int  statuses_seen = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;
    bit  in_gaps_on = 1'b1;
    bit  out_gaps_on = 1'b1;
    bit  counting = 1'b0;

    sio_command_host_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] carry_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, acc} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

    task automatic note(input logic [1:0] kind, input logic [7:0] v, input logic dtr);
        step_results.push_back('{kind, v, dtr, 1'b0});
    endtask

    task automatic finish_status(input logic [7:0] v);
        note(KIND_STATUS, v, 1'b0);
        st = S_IDLE;
    endtask

    task automatic host_exchange_step(input t_in_word w);
        logic [7:0] frame_bytes [FRAME_BYTES];
        logic [7:0] ck;
        logic [7:0] d;
        d = w.data_byte;
        step_results.delete();
        case (w.operation)
            OP_START: begin
                frame_bytes[0] = w.device_id;
                frame_bytes[1] = w.command_code;
                frame_bytes[2] = w.aux_one;
                frame_bytes[3] = w.aux_two;
                cur_mode = w.transfer_mode;
                left = w.transfer_length[LENGTH_WIDTH-1:0];
                wsum = '0;
                ck = '0;
                note(KIND_DTR, 8'h00, 1'b1);
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    ck = carry_fold(ck, frame_bytes[i]);
                    note(KIND_TX, frame_bytes[i], 1'b0);
                end
                note(KIND_TX, ck, 1'b0);
                note(KIND_DTR, 8'h00, 1'b0);
                st = S_ACK_WAIT;
            end
            OP_RX: begin
                case (st)
                    S_ACK_WAIT: begin
                        if (cur_mode == MODE_READ || cur_mode == MODE_WRITE) begin
                            if (d == CH_NAK) begin
                                finish_status(d);
                            end else if (cur_mode == MODE_READ) begin
                                st = S_COMPLETE_WAIT;
                            end else if (left == 0) begin
                                note(KIND_TX, wsum, 1'b0);
                                st = S_WRITE_ACK;
                            end else begin
                                st = S_WRITE_DATA;
                            end
                        end else begin
                            st = S_STATUS;
                        end
                    end
                    S_COMPLETE_WAIT: begin
                        if (d == CH_CMPL) begin
                            st = (left == 0) ? S_READ_SUM : S_READ_DATA;
                        end else begin
                            finish_status(d);
                        end
                    end
                    S_READ_DATA: begin
                        note(KIND_RD, d, 1'b0);
                        left = left - 1'b1;
                        if (left == 0) begin
                            st = S_READ_SUM;
                        end
                    end
                    S_READ_SUM: finish_status(CH_CMPL);
                    S_WRITE_ACK: begin
                        if (d == CH_NAK) begin
                            finish_status(d);
                        end else begin
                            st = S_STATUS;
                        end
                    end
                    S_STATUS: finish_status(d);
                    default: ;
                endcase
            end
            OP_PAYLOAD: begin
                if (st == S_WRITE_DATA) begin
                    note(KIND_TX, d, 1'b0);
                    wsum = carry_fold(wsum, d);
                    left = left - 1'b1;
                    if (left == 0) begin
                        note(KIND_TX, wsum, 1'b0);
                        st = S_WRITE_ACK;
                    end
                end
            end
            default: ;
        endcase
        if (step_results.size() > 0) begin
            step_results[$].last = 1'b1;
        end
    endtask

    task automatic send_word(input t_row r);
        int          gap;
        t_host_state prev;
        if (!calm && in_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= r.word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        prev = st;
        host_exchange_step(r.word);
        words_sent++;
        if (counting && (r.word.operation == OP_START || prev != st || step_results.size() > 0)) begin
            rand_items++;
        end
        if (r.typed) begin
            if (r.typed_has) begin
                pending_results.push_back(r.typed_res);
            end
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_item(input t_in_word w);
        send_word('{w, 1'b0, 1'b0, '0});
    endtask

    function automatic t_in_word rand_word(input logic [1:0] op, input logic [7:0] d);
        t_in_word    w;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        w.operation = op;
        w.data_byte = d;
        return w;
    endfunction

    function automatic t_in_word start_w(input logic [7:0] dev, input logic [7:0] cmd,
                                         input logic [7:0] a1, input logic [7:0] a2,
                                         input logic [1:0] m, input logic [15:0] len);
        return '{OP_START, dev, cmd, a1, a2, m, len, 8'h00};
    endfunction

    function automatic t_in_word rx_w(input logic [7:0] d);
        return '{OP_RX, 8'h00, 8'h00, 8'h00, 8'h00, MODE_NONE, 16'h0000, d};
    endfunction

    function automatic t_in_word op_w(input logic [1:0] op, input logic [7:0] d);
        return '{op, 8'h00, 8'h00, 8'h00, 8'h00, MODE_NONE, 16'h0000, d};
    endfunction

    function automatic t_row any_r(input t_in_word w);
        return '{w, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_row none_r(input t_in_word w);
        return '{w, 1'b1, 1'b0, '0};
    endfunction

    function automatic t_row one_r(input t_in_word w, input logic [1:0] kind,
                                   input logic [7:0] v);
        return '{w, 1'b1, 1'b1, '{kind, v, 1'b0, 1'b1}};
    endfunction

    task automatic random_exchange();
        t_in_word   steps[$];
        t_in_word   w;
        logic [1:0] m;
        logic [15:0] len;
        logic [7:0] b;
        int         r;
        int         cut;
        r = $urandom_range(0, 9);
        m = (r < 2) ? MODE_NONE : (r == 2) ? MODE_SPARE : (r < 7) ? MODE_READ : MODE_WRITE;
        if (m == MODE_READ || m == MODE_WRITE) begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                              : 16'($urandom_range(0, 6));
        end else begin
            len = 16'($urandom);
        end
        w = rand_word(OP_START, 8'($urandom));
        w.transfer_mode = m;
        w.transfer_length = len;
        steps.push_back(w);
        case (m)
            MODE_READ: begin
                b = ($urandom_range(0, 9) == 0) ? CH_NAK : 8'($urandom);
                steps.push_back(rand_word(OP_RX, b));
                if (b != CH_NAK) begin
                    b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : CH_CMPL;
                    steps.push_back(rand_word(OP_RX, b));
                    if (b == CH_CMPL) begin
                        for (int i = 0; i < len; i++) begin
                            steps.push_back(rand_word(OP_RX, 8'($urandom)));
                        end
                        steps.push_back(rand_word(OP_RX, 8'($urandom)));
                    end
                end
            end
            MODE_WRITE: begin
                b = ($urandom_range(0, 9) == 0) ? CH_NAK : 8'($urandom);
                steps.push_back(rand_word(OP_RX, b));
                if (b != CH_NAK) begin
                    for (int i = 0; i < len; i++) begin
                        steps.push_back(rand_word(OP_PAYLOAD, 8'($urandom)));
                    end
                    b = ($urandom_range(0, 4) == 0) ? CH_NAK : 8'($urandom);
                    steps.push_back(rand_word(OP_RX, b));
                    if (b != CH_NAK) begin
                        steps.push_back(rand_word(OP_RX, 8'($urandom)));
                    end
                end
            end
            default: begin
                steps.push_back(rand_word(OP_RX, 8'($urandom)));
                steps.push_back(rand_word(OP_RX, 8'($urandom)));
            end
        endcase
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, steps.size() - 1) : -1;
        in_gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) begin
            send_item(rand_word(OP_RX, 8'($urandom)));
        end
        for (int i = 0; i < steps.size(); i++) begin
            if (i == cut) begin
                break;
            end
            if ($urandom_range(0, 15) == 0) begin
                send_item(rand_word(($urandom_range(0, 1) == 0 || m == MODE_WRITE) ?
                                    OP_SPARE : OP_PAYLOAD, 8'($urandom)));
            end
            send_item(steps[i]);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && out_gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if ($urandom_range(0, 199) == 0) begin
            out_gaps_on = !out_gaps_on;
        end
        if (calm) begin
            stall_left = 0;
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("Unexpected result word: kind %0d value %0h dtr %0b last %0b",
                       o_out_word.kind, o_out_word.byte_value, o_out_word.dtr_level,
                       o_out_word.last);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.kind == KIND_STATUS) begin
                    statuses_seen++;
                end
                if (o_out_word.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_out_word.kind);
                    errors++;
                end
                if (o_out_word.byte_value !== want.byte_value) begin
                    $error("byte_value: expected %0h, actual %0h",
                           want.byte_value, o_out_word.byte_value);
                    errors++;
                end
                if (o_out_word.dtr_level !== want.dtr_level) begin
                    $error("dtr_level: expected %0b, actual %0b",
                           want.dtr_level, o_out_word.dtr_level);
                    errors++;
                end
                if (o_out_word.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_out_word.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        dir_rows.push_back(none_r(op_w(OP_PAYLOAD, 8'hFF)));
        dir_rows.push_back(none_r(rx_w(8'hFF)));
        dir_rows.push_back(none_r(op_w(OP_SPARE, 8'hFF)));
        dir_rows.push_back(any_r(start_w(8'hFF, 8'hFF, 8'hFF, 8'hFF, MODE_READ, 16'hFFFF)));
        dir_rows.push_back(one_r(rx_w(CH_NAK), KIND_STATUS, CH_NAK));
        dir_rows.push_back(any_r(start_w(8'h00, 8'h00, 8'h00, 8'h00, MODE_NONE, 16'h0000)));
        dir_rows.push_back(none_r(rx_w(8'hFF)));
        dir_rows.push_back(one_r(rx_w(8'h00), KIND_STATUS, 8'h00));
        dir_rows.push_back(any_r(start_w(8'h31, 8'h52, 8'h01, 8'h00, MODE_SPARE, 16'h0080)));
        dir_rows.push_back(none_r(rx_w(8'h12)));
        dir_rows.push_back(one_r(rx_w(8'hED), KIND_STATUS, 8'hED));
        dir_rows.push_back(any_r(start_w(8'h31, 8'h53, 8'h00, 8'h00, MODE_READ, 16'h0000)));
        dir_rows.push_back(none_r(rx_w(CH_ACK)));
        dir_rows.push_back(none_r(rx_w(CH_CMPL)));
        dir_rows.push_back(one_r(rx_w(8'h99), KIND_STATUS, CH_CMPL));
        dir_rows.push_back(any_r(start_w(8'h32, 8'h52, 8'h10, 8'h00, MODE_READ, 16'h0002)));
        dir_rows.push_back(none_r(rx_w(CH_ACK)));
        dir_rows.push_back(any_r(start_w(8'h31, 8'h57, 8'h20, 8'h00, MODE_WRITE, 16'h0000)));
        dir_rows.push_back(one_r(rx_w(CH_ACK), KIND_TX, 8'h00));
        dir_rows.push_back(one_r(rx_w(CH_NAK), KIND_STATUS, CH_NAK));
        dir_rows.push_back(any_r(start_w(8'hA5, 8'h5A, 8'hC3, 8'h3C, MODE_WRITE, 16'h0002)));
        dir_rows.push_back(none_r(rx_w(CH_ACK)));
        dir_rows.push_back(any_r(op_w(OP_PAYLOAD, 8'hFF)));
        dir_rows.push_back(any_r(op_w(OP_PAYLOAD, 8'hFF)));
        dir_rows.push_back(none_r(rx_w(CH_ACK)));
        dir_rows.push_back(one_r(rx_w(8'h01), KIND_STATUS, 8'h01));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i]);

        counting = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            random_exchange();
            if (rand_items >= CALM_AFTER) begin
                calm = 1'b1;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input words (%0d directed rows, %0d effective random).",
                 words_sent, dir_rows.size(), rand_items);
        $display("Checked %0d result words, %0d of them statuses, with %0d mismatches.",
                 results_seen, statuses_seen, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
